// File: rtl/pmc_pkg.sv
// ----------------------------------------------------------------------------
// pmc_pkg: shared types, constants and helpers for the polyline mapper
// Holds widths, command and job codes, state types, the configuration record
// and the rectangle helpers used by the front and back sections.
// ----------------------------------------------------------------------------
package pmc_pkg;

	// Field widths.
	localparam int VALUE_BITS      = 32;
	localparam int PIXEL_FRAC_BITS = 4;
	localparam int CFG_W           = 12;
	localparam int GAIN_W          = 32;
	localparam int PIX_W           = 20;
	localparam int CFG_IDX_W       = 4;

	// Mapping datapath widths.
	localparam int EDGE_W       = CFG_W + 1 + PIXEL_FRAC_BITS;
	localparam int MAG_W        = VALUE_BITS + 1;
	localparam int P1_W         = MAG_W + GAIN_W;
	localparam int P2_W         = P1_W + CFG_W;
	localparam int SHIFT        = GAIN_W - PIXEL_FRAC_BITS;
	localparam int OFF_CAP_BITS = 26;
	localparam int OFF_W        = OFF_CAP_BITS + 2;
	localparam int SUM_W        = OFF_W + 2;

	// Clipping datapath widths.
	localparam int CW     = PIX_W + 2;
	localparam int PW     = 2 * CW;
	localparam int DSR_W  = CW + 1;
	localparam int QW     = 24;
	localparam int QCNT_W = $clog2(QW + 1);

	// Job queue.
	localparam int QDEPTH = 2;
	localparam int QPTR_W = $clog2(QDEPTH);

	localparam int PIX_MAXV = (1 << (PIX_W - 1)) - 1;
	localparam int PIX_MINV = -(1 << (PIX_W - 1));

	typedef enum logic {
		CMD_MOVE = 1'b0,
		CMD_LINE = 1'b1
	} cmd_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PLOT_LEFT   = 4'd0,
		REG_PLOT_TOP    = 4'd1,
		REG_PLOT_WIDTH  = 4'd2,
		REG_PLOT_HEIGHT = 4'd3,
		REG_X_ORIGIN    = 4'd4,
		REG_X_GAIN      = 4'd5,
		REG_Y_ORIGIN    = 4'd6,
		REG_Y_GAIN      = 4'd7
	} reg_idx_t;

	typedef enum logic [1:0] {
		JOB_MOVE = 2'd0,
		JOB_LINE = 2'd1,
		JOB_NEAR = 2'd2,
		JOB_FAR  = 2'd3
	} job_kind_t;

	typedef enum logic [2:0] {
		F_IDLE,
		F_MUL1,
		F_MUL2,
		F_MAP,
		F_PUSH
	} front_state_t;

	typedef enum logic [3:0] {
		B_IDLE,
		B_PT,
		B_SETUP,
		B_MULN,
		B_UPDN,
		B_UPDF,
		B_MULC,
		B_CHECK,
		B_MULQ,
		B_DIVX,
		B_DIVY,
		B_EMIT,
		B_FAIL
	} back_state_t;

	typedef struct packed {
		logic [CFG_W-1:0]             left;
		logic [CFG_W-1:0]             top;
		logic [CFG_W-1:0]             width;
		logic [CFG_W-1:0]             height;
		logic signed [VALUE_BITS-1:0] x_origin;
		logic [GAIN_W-1:0]            x_gain;
		logic signed [VALUE_BITS-1:0] y_origin;
		logic [GAIN_W-1:0]            y_gain;
	} cfg_t;

	typedef struct packed {
		logic [EDGE_W-1:0] l;
		logic [EDGE_W-1:0] r;
		logic [EDGE_W-1:0] t;
		logic [EDGE_W-1:0] b;
	} edges_t;

	typedef struct packed {
		job_kind_t               kind;
		logic signed [PIX_W-1:0] x1;
		logic signed [PIX_W-1:0] y1;
		logic signed [PIX_W-1:0] x2;
		logic signed [PIX_W-1:0] y2;
	} job_t;

	// Rectangle edges on the sub-pixel grid.
	function automatic edges_t calc_edges(input cfg_t c);
		edges_t e;
		e.l = EDGE_W'(c.left) << PIXEL_FRAC_BITS;
		e.r = (EDGE_W'(c.left) + EDGE_W'(c.width)) << PIXEL_FRAC_BITS;
		e.t = EDGE_W'(c.top) << PIXEL_FRAC_BITS;
		e.b = (EDGE_W'(c.top) + EDGE_W'(c.height)) << PIXEL_FRAC_BITS;
		return e;
	endfunction

	// Closed rectangle test.
	function automatic logic in_rect(input logic signed [PIX_W-1:0] x,
			input logic signed [PIX_W-1:0] y, input edges_t e);
		logic signed [PIX_W:0] xe, ye, l, r, t, b;
		xe = (PIX_W+1)'(x);
		ye = (PIX_W+1)'(y);
		l  = $signed((PIX_W+1)'(e.l));
		r  = $signed((PIX_W+1)'(e.r));
		t  = $signed((PIX_W+1)'(e.t));
		b  = $signed((PIX_W+1)'(e.b));
		return (xe >= l) && (xe <= r) && (ye >= t) && (ye <= b);
	endfunction

	// Saturate to the pixel field range.
	function automatic logic signed [PIX_W-1:0] sat_pix(input logic signed [31:0] v);
		logic signed [PIX_W-1:0] s;
		if (v > PIX_MAXV) begin
			s = PIX_W'(PIX_MAXV);
		end else if (v < PIX_MINV) begin
			s = PIX_W'(PIX_MINV);
		end else begin
			s = PIX_W'(v);
		end
		return s;
	endfunction

endpackage

// File: rtl/polyline_map_and_clip_core.sv
// ----------------------------------------------------------------------------
// polyline_map_and_clip_core: data point to clipped plot path commands
// Holds the configuration registers and joins the mapper, the job queue and
// the clipper.
//
//   Channel   Handshake                 Payload
//   input     in_valid / in_stall       value_x, value_y, signal_start
//   output    out_valid / out_stall     command, pixel_x, pixel_y, last
//   config    cfg_valid / cfg_ready     cfg_index, cfg_data
//
// The mapper takes no new point until the last has passed its two multiplier
// stages, the map step and the push. A point inside after inside, or a first
// point, passes through the clipper's point state to the output register.
// A clipped segment needs two 24-step serial divisions. Reset clears the path
// state, the queue and the output valid; the configuration returns to its reset
// values. Stalls hold only their own side while the two-entry queue has room.
// ----------------------------------------------------------------------------
module polyline_map_and_clip_core (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   in_valid,
	output logic                                   in_stall,
	input  logic signed [pmc_pkg::VALUE_BITS-1:0]  value_x,
	input  logic signed [pmc_pkg::VALUE_BITS-1:0]  value_y,
	input  logic                                   signal_start,
	output logic                                   out_valid,
	input  logic                                   out_stall,
	output logic                                   command,
	output logic signed [pmc_pkg::PIX_W-1:0]       pixel_x,
	output logic signed [pmc_pkg::PIX_W-1:0]       pixel_y,
	output logic                                   last,
	input  logic                                   cfg_valid,
	output logic                                   cfg_ready,
	input  logic [pmc_pkg::CFG_IDX_W-1:0]          cfg_index,
	input  logic [pmc_pkg::VALUE_BITS-1:0]         cfg_data
);
	import pmc_pkg::*;

	cfg_t   cfg_q;
	edges_t edges;
	logic   push, full, pop, empty;
	job_t   push_job, pop_job;

	assign cfg_ready = 1'b1;
	assign edges     = calc_edges(cfg_q);

	// Configuration register writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.left     <= '0;
			cfg_q.top      <= '0;
			cfg_q.width    <= CFG_W'(640);
			cfg_q.height   <= CFG_W'(480);
			cfg_q.x_origin <= '0;
			cfg_q.x_gain   <= GAIN_W'(65536);
			cfg_q.y_origin <= '0;
			cfg_q.y_gain   <= GAIN_W'(65536);
		end else if (cfg_valid && cfg_ready) begin
			case (reg_idx_t'(cfg_index))
				REG_PLOT_LEFT:   cfg_q.left     <= cfg_data[CFG_W-1:0];
				REG_PLOT_TOP:    cfg_q.top      <= cfg_data[CFG_W-1:0];
				REG_PLOT_WIDTH:  cfg_q.width    <= cfg_data[CFG_W-1:0];
				REG_PLOT_HEIGHT: cfg_q.height   <= cfg_data[CFG_W-1:0];
				REG_X_ORIGIN:    cfg_q.x_origin <= $signed(cfg_data);
				REG_X_GAIN:      cfg_q.x_gain   <= cfg_data[GAIN_W-1:0];
				REG_Y_ORIGIN:    cfg_q.y_origin <= $signed(cfg_data);
				REG_Y_GAIN:      cfg_q.y_gain   <= cfg_data[GAIN_W-1:0];
				default: begin
				end
			endcase
		end
	end

	pmc_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.edges        (edges),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.value_x      (value_x),
		.value_y      (value_y),
		.signal_start (signal_start),
		.push         (push),
		.push_job     (push_job),
		.full         (full)
	);

	pmc_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.full     (full),
		.pop      (pop),
		.pop_job  (pop_job),
		.empty    (empty)
	);

	pmc_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.edges     (edges),
		.empty     (empty),
		.pop_job   (pop_job),
		.pop       (pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.command   (command),
		.pixel_x   (pixel_x),
		.pixel_y   (pixel_y),
		.last      (last)
	);

endmodule

// File: rtl/pmc_queue.sv
// ----------------------------------------------------------------------------
// pmc_queue: short job queue between front and back
// A small register FIFO that lets the mapper and the clipper stall on their own.
// ----------------------------------------------------------------------------
module pmc_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  pmc_pkg::job_t  push_job,
	output logic           full,
	input  logic           pop,
	output pmc_pkg::job_t  pop_job,
	output logic           empty
);
	import pmc_pkg::*;

	job_t                mem_q [QDEPTH];
	logic [QPTR_W-1:0]   wr_ptr_q;
	logic [QPTR_W-1:0]   rd_ptr_q;
	logic [QPTR_W:0]     cnt_q;

	assign full    = (cnt_q == (QPTR_W+1)'(QDEPTH));
	assign empty   = (cnt_q == '0);
	assign pop_job = mem_q[rd_ptr_q];

	// Storage is written only on a push.
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

// File: rtl/pmc_front.sv
// ----------------------------------------------------------------------------
// pmc_front: point mapper and classifier
// Maps one data point at a time to the sub-pixel grid, tracks the
// previous point and the subpath flag, and queues the work for the clipper.
// ----------------------------------------------------------------------------
module pmc_front (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  pmc_pkg::cfg_t                          cfg,
	input  pmc_pkg::edges_t                        edges,
	input  logic                                   in_valid,
	output logic                                   in_stall,
	input  logic signed [pmc_pkg::VALUE_BITS-1:0]  value_x,
	input  logic signed [pmc_pkg::VALUE_BITS-1:0]  value_y,
	input  logic                                   signal_start,
	output logic                                   push,
	output pmc_pkg::job_t                          push_job,
	input  logic                                   full
);
	import pmc_pkg::*;

	localparam int R_W = P2_W + 1 - SHIFT;
	localparam logic [P2_W:0]  RND   = (P2_W+1)'((64'd1 << SHIFT) - 64'd1);
	localparam logic [R_W-1:0] CAP_R = R_W'(64'd1 << OFF_CAP_BITS);

	front_state_t state_q, state_d;

	logic                    ss_q;
	logic                    negx_q, negy_q;
	logic [MAG_W-1:0]        magx_q, magy_q;
	logic [P1_W-1:0]         p1x_q, p1y_q;
	logic [P2_W-1:0]         p2x_q, p2y_q;
	logic signed [PIX_W-1:0] cx_q, cy_q;
	logic signed [PIX_W-1:0] prev_px_q, prev_py_q;
	logic                    prev_valid_q, path_started_q;

	logic                    accept;
	logic signed [MAG_W-1:0] diffx, diffy;
	logic [P2_W:0]           adjx, adjy;
	logic [R_W-1:0]          rx, ry;
	logic [OFF_CAP_BITS:0]   offmx, offmy;
	logic signed [OFF_W-1:0] offx, offy;
	logic signed [SUM_W-1:0] sumx, sumy;
	logic                    has_job, advance, cin, pin, ps, pv;
	job_kind_t               kind;

	assign in_stall = (state_q != F_IDLE);
	assign accept   = in_valid && !in_stall;

	// Offsets from the origins, split into sign and magnitude.
	assign diffx = $signed(MAG_W'(value_x)) - $signed(MAG_W'(cfg.x_origin));
	assign diffy = $signed(MAG_W'(value_y)) - $signed(MAG_W'(cfg.y_origin));

	// Round toward minus infinity, drop the fraction and clamp the offset.
	always_comb begin
		adjx  = {1'b0, p2x_q} + (negx_q ? RND : '0);
		adjy  = {1'b0, p2y_q} + (negy_q ? RND : '0);
		rx    = adjx[P2_W:SHIFT];
		ry    = adjy[P2_W:SHIFT];
		offmx = (rx > CAP_R) ? CAP_R[OFF_CAP_BITS:0] : rx[OFF_CAP_BITS:0];
		offmy = (ry > CAP_R) ? CAP_R[OFF_CAP_BITS:0] : ry[OFF_CAP_BITS:0];
		offx  = negx_q ? -$signed({1'b0, offmx}) : $signed({1'b0, offmx});
		offy  = negy_q ? -$signed({1'b0, offmy}) : $signed({1'b0, offmy});
		sumx  = $signed(SUM_W'(edges.l)) + SUM_W'(offx);
		sumy  = $signed(SUM_W'(edges.b)) - SUM_W'(offy);
	end

	// Classify the point against the previous one.
	always_comb begin
		ps      = path_started_q && !ss_q;
		pv      = prev_valid_q && !ss_q;
		cin     = in_rect(cx_q, cy_q, edges);
		pin     = in_rect(prev_px_q, prev_py_q, edges);
		has_job = 1'b0;
		kind    = JOB_LINE;
		if (cin) begin
			has_job = 1'b1;
			if (!ps) begin
				kind = JOB_MOVE;
			end else if (pv && !pin) begin
				kind = JOB_NEAR;
			end else begin
				kind = JOB_LINE;
			end
		end else if (pv && pin) begin
			has_job = 1'b1;
			kind    = JOB_FAR;
		end
		push_job.kind = kind;
		push_job.x1   = prev_px_q;
		push_job.y1   = prev_py_q;
		push_job.x2   = cx_q;
		push_job.y2   = cy_q;
	end

	assign advance = (state_q == F_PUSH) && (!has_job || !full);
	assign push    = (state_q == F_PUSH) && has_job && !full;

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			F_IDLE: begin
				if (accept) begin
					state_d = F_MUL1;
				end
			end
			F_MUL1: state_d = F_MUL2;
			F_MUL2: state_d = F_MAP;
			F_MAP:  state_d = F_PUSH;
			F_PUSH: begin
				if (advance) begin
					state_d = F_IDLE;
				end
			end
			default: state_d = F_IDLE;
		endcase
	end

	// Mapping datapath.
	always_ff @(posedge clk) begin
		if (accept) begin
			ss_q   <= signal_start;
			negx_q <= diffx[MAG_W-1];
			negy_q <= diffy[MAG_W-1];
			magx_q <= diffx[MAG_W-1] ? MAG_W'(-diffx) : MAG_W'(diffx);
			magy_q <= diffy[MAG_W-1] ? MAG_W'(-diffy) : MAG_W'(diffy);
		end
		if (state_q == F_MUL1) begin
			p1x_q <= magx_q * cfg.x_gain;
			p1y_q <= magy_q * cfg.y_gain;
		end
		if (state_q == F_MUL2) begin
			p2x_q <= p1x_q * cfg.width;
			p2y_q <= p1y_q * cfg.height;
		end
		if (state_q == F_MAP) begin
			cx_q <= sat_pix(32'(sumx));
			cy_q <= sat_pix(32'(sumy));
		end
	end

	// Sequencer and the path tracking state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= F_IDLE;
			prev_px_q      <= '0;
			prev_py_q      <= '0;
			prev_valid_q   <= 1'b0;
			path_started_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (advance) begin
				prev_px_q      <= cx_q;
				prev_py_q      <= cy_q;
				prev_valid_q   <= 1'b1;
				path_started_q <= ps || cin;
			end
		end
	end

endmodule

// File: rtl/pmc_div.sv
// ----------------------------------------------------------------------------
// pmc_div: bit-serial unsigned divider
// Restoring division, one quotient bit per cycle, for quotients below 2^QW.
// ----------------------------------------------------------------------------
module pmc_div (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [pmc_pkg::PW-1:0]     dividend,
	input  logic [pmc_pkg::DSR_W-1:0]  divisor,
	output logic                       done,
	output logic [pmc_pkg::QW-1:0]     quotient
);
	import pmc_pkg::*;

	logic [DSR_W-1:0]  rem_q;
	logic [QW-1:0]     quo_q;
	logic [DSR_W-1:0]  dsr_q;
	logic [QCNT_W-1:0] cnt_q;
	logic              busy_q, done_q;
	logic [DSR_W:0]    trial;
	logic              fits;

	assign trial    = {rem_q, quo_q[QW-1]};
	assign fits     = (trial >= {1'b0, dsr_q});
	assign done     = done_q;
	assign quotient = quo_q;

	// Shift and subtract datapath.
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= DSR_W'(dividend[PW-1:QW]);
			quo_q <= dividend[QW-1:0];
			dsr_q <= divisor;
		end else if (busy_q) begin
			rem_q <= fits ? DSR_W'(trial - {1'b0, dsr_q}) : DSR_W'(trial);
			quo_q <= {quo_q[QW-2:0], fits};
		end
	end

	// Step counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= QCNT_W'(QW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == QCNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

endmodule

// File: rtl/pmc_back.sv
// ----------------------------------------------------------------------------
// pmc_back: segment clipper and command emitter
// Takes queued jobs, runs the slab clipping with a shared multiplier pair and
// the serial divider, and presents commands through an output register.
// ----------------------------------------------------------------------------
module pmc_back (
	input  logic                              clk,
	input  logic                              arst_n,
	input  pmc_pkg::edges_t                   edges,
	input  logic                              empty,
	input  pmc_pkg::job_t                     pop_job,
	output logic                              pop,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic                              command,
	output logic signed [pmc_pkg::PIX_W-1:0]  pixel_x,
	output logic signed [pmc_pkg::PIX_W-1:0]  pixel_y,
	output logic                              last
);
	import pmc_pkg::*;

	back_state_t state_q, state_d;

	job_t                 job_q;
	logic signed [CW-1:0] dx_q, dy_q, loy_q, hiy_q, ady_q;
	logic signed [CW-1:0] n0_q, d0_q, n1_q, d1_q, dsel_q;
	logic                 dy_nz_q;
	logic signed [PW-1:0] pa_q, pb_q;
	logic signed [PIX_W-1:0] ix_q, iy_q;

	logic                    out_valid_q, last_q;
	cmd_t                    cmd_q;
	logic signed [PIX_W-1:0] px_q, py_q;

	// Setup values.
	logic signed [CW-1:0] x1e, y1e, x2e, y2e, dx, dy, el, er, et, eb;
	logic signed [CW-1:0] ax, bx, ay, by, lox, hix, adx, loy, hiy, ady;
	logic signed [CW-1:0] n0, d0, n1, d1, nsel;
	logic                 fail;
	logic                 chk_fail;

	// Shared multipliers, divider hookup and output load.
	logic signed [CW-1:0]  ma0, mb0, ma1, mb1;
	logic                  mul_en;
	logic                  div_start, div_done;
	logic [PW-1:0]         div_dividend;
	logic [DSR_W-1:0]      div_divisor;
	logic [QW-1:0]         div_q;
	logic signed [PW-1:0]  num;
	logic [PW-1:0]         num_mag;
	logic signed [QW+1:0]  qs;
	logic signed [QW+1:0]  res_sum;
	logic signed [PIX_W-1:0] res_pix;
	logic                  out_free, out_load, out_last;
	cmd_t                  out_cmd;
	logic signed [PIX_W-1:0] out_x, out_y;
	logic                  is_far;

	assign out_free = !out_valid_q || !out_stall;
	assign is_far   = (job_q.kind == JOB_FAR);

	// First slab and the axis checks for the clipper setup.
	always_comb begin
		x1e = CW'(job_q.x1);
		y1e = CW'(job_q.y1);
		x2e = CW'(job_q.x2);
		y2e = CW'(job_q.y2);
		el  = $signed(CW'(edges.l));
		er  = $signed(CW'(edges.r));
		et  = $signed(CW'(edges.t));
		eb  = $signed(CW'(edges.b));
		dx  = x2e - x1e;
		dy  = y2e - y1e;
		ax  = el - x1e;
		bx  = er - x1e;
		adx = dx;
		if (dx < 0) begin
			ax  = -ax;
			bx  = -bx;
			adx = -dx;
		end
		ay  = et - y1e;
		by  = eb - y1e;
		ady = dy;
		if (dy < 0) begin
			ay  = -ay;
			by  = -by;
			ady = -dy;
		end
		lox  = (ax < bx) ? ax : bx;
		hix  = (ax < bx) ? bx : ax;
		loy  = (ay < by) ? ay : by;
		hiy  = (ay < by) ? by : ay;
		fail = (dx == 0) && (dy == 0);
		n0   = CW'(0);
		d0   = CW'(1);
		n1   = CW'(1);
		d1   = CW'(1);
		if (dx != 0) begin
			if (lox > 0) begin
				n0 = lox;
				d0 = adx;
			end
			if (hix < adx) begin
				n1 = hix;
				d1 = adx;
			end
		end else if ((x1e < el) || (x1e > er)) begin
			fail = 1'b1;
		end
		if ((dy == 0) && ((y1e < et) || (y1e > eb))) begin
			fail = 1'b1;
		end
	end

	assign nsel = is_far ? n1_q : n0_q;

	// Empty parameter interval: the cross products from the compare step.
	assign chk_fail = (pa_q > pb_q) || (n0_q < 0) || (n0_q > d0_q);

	// Multiplier operand selection per step.
	always_comb begin
		ma0    = loy_q;
		mb0    = d0_q;
		ma1    = n0_q;
		mb1    = ady_q;
		mul_en = 1'b0;
		case (state_q)
			B_MULN: begin
				mul_en = 1'b1;
			end
			B_UPDN: begin
				ma0    = hiy_q;
				mb0    = d1_q;
				ma1    = n1_q;
				mb1    = ady_q;
				mul_en = 1'b1;
			end
			B_MULC: begin
				ma0    = n0_q;
				mb0    = d1_q;
				ma1    = n1_q;
				mb1    = d0_q;
				mul_en = 1'b1;
			end
			B_CHECK: begin
				ma0    = nsel;
				mb0    = dx_q;
				ma1    = nsel;
				mb1    = dy_q;
				mul_en = 1'b1;
			end
			default: mul_en = 1'b0;
		endcase
	end

	// Rounded division operands: (2|n*delta| + d) / 2d.
	always_comb begin
		num          = (state_q == B_MULQ) ? pa_q : pb_q;
		num_mag      = num[PW-1] ? PW'(-num) : PW'(num);
		div_dividend = PW'({num_mag, 1'b0}) + PW'(dsel_q);
		div_divisor  = DSR_W'({dsel_q, 1'b0});
		div_start    = (state_q == B_MULQ) || ((state_q == B_DIVX) && div_done);
	end

	// Add the signed step to the start point and saturate.
	always_comb begin
		qs      = $signed({2'b00, div_q});
		if (((state_q == B_DIVX) ? pa_q[PW-1] : pb_q[PW-1])) begin
			qs = -qs;
		end
		res_sum = ((state_q == B_DIVX) ? (QW+2)'(job_q.x1) : (QW+2)'(job_q.y1)) + qs;
		res_pix = sat_pix(32'(res_sum));
	end

	// Next state, queue pop and output load.
	always_comb begin
		state_d  = state_q;
		pop      = 1'b0;
		out_load = 1'b0;
		out_cmd  = CMD_LINE;
		out_x    = job_q.x2;
		out_y    = job_q.y2;
		out_last = 1'b1;
		case (state_q)
			B_IDLE: begin
				if (!empty) begin
					pop = 1'b1;
					if ((pop_job.kind == JOB_MOVE) || (pop_job.kind == JOB_LINE)) begin
						state_d = B_PT;
					end else begin
						state_d = B_SETUP;
					end
				end
			end
			B_PT: begin
				out_cmd = (job_q.kind == JOB_MOVE) ? CMD_MOVE : CMD_LINE;
				if (out_free) begin
					out_load = 1'b1;
					state_d  = B_IDLE;
				end
			end
			B_SETUP: begin
				state_d = fail ? B_FAIL : B_MULN;
			end
			B_MULN: state_d = B_UPDN;
			B_UPDN: state_d = B_UPDF;
			B_UPDF: state_d = B_MULC;
			B_MULC: state_d = B_CHECK;
			B_CHECK: begin
				state_d = chk_fail ? B_FAIL : B_MULQ;
			end
			B_MULQ: state_d = B_DIVX;
			B_DIVX: begin
				if (div_done) begin
					state_d = B_DIVY;
				end
			end
			B_DIVY: begin
				if (div_done) begin
					state_d = B_EMIT;
				end
			end
			B_EMIT: begin
				out_cmd  = is_far ? CMD_LINE : CMD_MOVE;
				out_x    = ix_q;
				out_y    = iy_q;
				out_last = is_far;
				if (out_free) begin
					out_load = 1'b1;
					state_d  = is_far ? B_IDLE : B_PT;
				end
			end
			B_FAIL: begin
				// A missed entry restarts the subpath at the point; a missed exit
				// draws nothing.
				out_cmd = CMD_MOVE;
				if (is_far) begin
					state_d = B_IDLE;
				end else if (out_free) begin
					out_load = 1'b1;
					state_d  = B_IDLE;
				end
			end
			default: state_d = B_IDLE;
		endcase
	end

	pmc_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.done     (div_done),
		.quotient (div_q)
	);

	// Clipper datapath registers.
	always_ff @(posedge clk) begin
		if (pop) begin
			job_q <= pop_job;
		end
		if (mul_en) begin
			pa_q <= ma0 * mb0;
			pb_q <= ma1 * mb1;
		end
		case (state_q)
			B_SETUP: begin
				dx_q    <= dx;
				dy_q    <= dy;
				loy_q   <= loy;
				hiy_q   <= hiy;
				ady_q   <= ady;
				dy_nz_q <= (dy != 0);
				n0_q    <= n0;
				d0_q    <= d0;
				n1_q    <= n1;
				d1_q    <= d1;
			end
			B_UPDN: begin
				if (dy_nz_q && (pa_q > pb_q)) begin
					n0_q <= loy_q;
					d0_q <= ady_q;
				end
			end
			B_UPDF: begin
				if (dy_nz_q && (pa_q < pb_q)) begin
					n1_q <= hiy_q;
					d1_q <= ady_q;
				end
			end
			B_CHECK: begin
				dsel_q <= is_far ? d1_q : d0_q;
			end
			B_DIVX: begin
				if (div_done) begin
					ix_q <= res_pix;
				end
			end
			B_DIVY: begin
				if (div_done) begin
					iy_q <= res_pix;
				end
			end
			default: begin
			end
		endcase
		if (out_load) begin
			cmd_q  <= out_cmd;
			px_q   <= out_x;
			py_q   <= out_y;
			last_q <= out_last;
		end
	end

	// Sequencer and output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign command   = cmd_q;
	assign pixel_x   = px_q;
	assign pixel_y   = py_q;
	assign last      = last_q;

endmodule

// File: tb/sv/tb_polyline_map_and_clip_core.sv
// ----------------------------------------------------------------------------
// tb_polyline_map_and_clip_core: self-checking bench for the polyline mapper
// Drives data points in bursts against a stalling receiver. Each accepted
// request runs through a bench-side map-and-clip model. Every path command
// that comes out is compared with the oldest expected one. The bench steps
// through several register settings, the extremes among them.
// ----------------------------------------------------------------------------
module tb_polyline_map_and_clip_core;
	import pmc_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int HOLD_CYCLES  = 400;
	localparam int SETTLE       = 150;
	localparam int IDLE_LIMIT   = 5000;

	typedef struct {
		cmd_t                    cmd;
		logic signed [PIX_W-1:0] px;
		logic signed [PIX_W-1:0] py;
		logic                    lst;
	} path_cmd_t;

	typedef struct {
		logic [31:0] x;
		logic [31:0] y;
		logic        s;
		int          n_typed;   // -1: use the model
		path_cmd_t   e0;
	} point_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic signed [VALUE_BITS-1:0] value_x = '0;
	logic signed [VALUE_BITS-1:0] value_y = '0;
	logic signal_start = 1'b0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic command;
	logic signed [PIX_W-1:0] pixel_x, pixel_y;
	logic last;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [VALUE_BITS-1:0] cfg_data = '0;

	// Typed expectation travels with the request payload.
	int        row_typed = -1;
	path_cmd_t row_exp;

	path_cmd_t cmd_q[$];
	int        errors = 0;
	bit        hold_req = 1'b0;
	int        idle_cycles = 0;

	// Bench copy of the registers and path state.
	logic [11:0] m_left, m_top, m_width, m_height;
	logic [31:0] m_xo, m_xg, m_yo, m_yg;
	longint      m_prev_x, m_prev_y;
	bit          m_prev_ok, m_started;

	polyline_map_and_clip_core DUT (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.value_x(value_x), .value_y(value_y), .signal_start(signal_start),
		.out_valid(out_valid), .out_stall(out_stall),
		.command(command), .pixel_x(pixel_x), .pixel_y(pixel_y), .last(last),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always #2 clk = ~clk;

	// ---------------- Model of the mapper and clipper ----------------
	function automatic longint sat20(longint v);
		if (v > PIX_MAXV) return PIX_MAXV;
		if (v < PIX_MINV) return PIX_MINV;
		return v;
	endfunction

	function automatic longint map_off(longint diff, logic [31:0] gain, logic [11:0] size);
		logic [127:0] p;
		bit neg;
		longint r;
		neg = diff < 0;
		p = neg ? 128'(-diff) : 128'(diff);
		p = p * 128'(gain) * 128'(size);
		if (neg) p = p + ((128'd1 << 28) - 1);
		p = p >> 28;
		if (p > (128'd1 << 26)) p = 128'd1 << 26;
		r = longint'(p);
		return neg ? -r : r;
	endfunction

	function automatic longint e_l(); return longint'(m_left) << 4; endfunction
	function automatic longint e_r(); return (longint'(m_left) + m_width) << 4; endfunction
	function automatic longint e_t(); return longint'(m_top) << 4; endfunction
	function automatic longint e_b(); return (longint'(m_top) + m_height) << 4; endfunction

	function automatic bit in_box(longint x, longint y);
		return x >= e_l() && x <= e_r() && y >= e_t() && y <= e_b();
	endfunction

	function automatic longint round_div(longint n, longint d);
		longint mag, q;
		mag = n < 0 ? -n : n;
		q = (2 * mag + d) / (2 * d);
		return n < 0 ? -q : q;
	endfunction

	function automatic void slab(longint lo_e, longint hi_e, longint p, longint d,
			inout longint n0, inout longint d0, inout longint n1, inout longint d1);
		longint a, b, lo, hi;
		a = lo_e - p;
		b = hi_e - p;
		if (d < 0) begin
			a = -a; b = -b; d = -d;
		end
		lo = a < b ? a : b;
		hi = a < b ? b : a;
		if (lo * d0 > n0 * d) begin
			n0 = lo; d0 = d;
		end
		if (hi * d1 < n1 * d) begin
			n1 = hi; d1 = d;
		end
	endfunction

	function automatic bit clip_seg(longint x1, longint y1, longint x2, longint y2,
			bit far_end, output longint ox, output longint oy);
		longint dx, dy, n0, d0, n1, d1, n, d;
		dx = x2 - x1; dy = y2 - y1;
		n0 = 0; d0 = 1; n1 = 1; d1 = 1;
		ox = 0; oy = 0;
		if (dx == 0 && dy == 0) return 1'b0;
		if (dx != 0) slab(e_l(), e_r(), x1, dx, n0, d0, n1, d1);
		else if (x1 < e_l() || x1 > e_r()) return 1'b0;
		if (dy != 0) slab(e_t(), e_b(), y1, dy, n0, d0, n1, d1);
		else if (y1 < e_t() || y1 > e_b()) return 1'b0;
		if (n0 * d1 > n1 * d0 || n0 < 0 || n0 > d0) return 1'b0;
		n = far_end ? n1 : n0;
		d = far_end ? d1 : d0;
		ox = sat20(x1 + round_div(n * dx, d));
		oy = sat20(y1 + round_div(n * dy, d));
		return 1'b1;
	endfunction

	function automatic path_cmd_t mk(cmd_t c, longint x, longint y);
		path_cmd_t r;
		r.cmd = c; r.px = PIX_W'(x); r.py = PIX_W'(y); r.lst = 1'b0;
		return r;
	endfunction

	// Maps one point, updates the path state, returns the commands it causes.
	function automatic int map_and_clip(logic [31:0] vx, logic [31:0] vy, bit s,
			output path_cmd_t res[2]);
		longint cx, cy, ix, iy;
		int n;
		n = 0;
		res[0] = mk(CMD_MOVE, 0, 0);
		res[1] = res[0];
		if (s) begin
			m_prev_ok = 1'b0; m_started = 1'b0;
		end
		cx = sat20(e_l() + map_off(longint'($signed(vx)) - longint'($signed(m_xo)),
			m_xg, m_width));
		cy = sat20(e_b() - map_off(longint'($signed(vy)) - longint'($signed(m_yo)),
			m_yg, m_height));
		if (in_box(cx, cy)) begin
			if (!m_started) begin
				res[n++] = mk(CMD_MOVE, cx, cy);
				m_started = 1'b1;
			end else if (m_prev_ok && !in_box(m_prev_x, m_prev_y)) begin
				if (clip_seg(m_prev_x, m_prev_y, cx, cy, 1'b0, ix, iy)) begin
					res[n++] = mk(CMD_MOVE, ix, iy);
					res[n++] = mk(CMD_LINE, cx, cy);
				end else begin
					res[n++] = mk(CMD_MOVE, cx, cy);
				end
			end else begin
				res[n++] = mk(CMD_LINE, cx, cy);
			end
		end else if (m_prev_ok && in_box(m_prev_x, m_prev_y)) begin
			if (clip_seg(m_prev_x, m_prev_y, cx, cy, 1'b1, ix, iy))
				res[n++] = mk(CMD_LINE, ix, iy);
		end
		m_prev_x = cx; m_prev_y = cy; m_prev_ok = 1'b1;
		if (n > 0) res[n-1].lst = 1'b1;
		return n;
	endfunction

	// ---------------- Request and result monitors ----------------
	always @(posedge clk) begin
		path_cmd_t res[2];
		path_cmd_t got, want;
		int n;
		if (arst_n && in_valid && !in_stall) begin
			n = map_and_clip(value_x, value_y, signal_start, res);
			if (row_typed >= 0) begin
				if (row_typed > 0) cmd_q.push_back(row_exp);
			end else begin
				for (int k = 0; k < n; k++) cmd_q.push_back(res[k]);
			end
		end
		if (arst_n && out_valid && !out_stall) begin
			got.cmd = cmd_t'(command); got.px = pixel_x; got.py = pixel_y; got.lst = last;
			if (cmd_q.size() == 0) begin
				$error("unexpected command %0d at (%0d,%0d)", command, pixel_x, pixel_y);
				errors++;
			end else begin
				want = cmd_q.pop_front();
				if (got.cmd !== want.cmd) begin
					$error("command: expected %0d, got %0d", want.cmd, got.cmd); errors++;
				end
				if (got.px !== want.px) begin
					$error("pixel_x: expected %0d, got %0d", want.px, got.px); errors++;
				end
				if (got.py !== want.py) begin
					$error("pixel_y: expected %0d, got %0d", want.py, got.py); errors++;
				end
				if (got.lst !== want.lst) begin
					$error("last: expected %0d, got %0d", want.lst, got.lst); errors++;
				end
			end
		end
	end

	// Watchdog on cycles with no handshake at all.
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	// Receiver stall pattern, with one long hold-off on request.
	always @(negedge clk) begin
		int hold_left;
		int mode_left;
		int mode;
		bit hold_done;
		if (hold_req && !hold_done) begin
			hold_done = 1'b1;
			hold_left = HOLD_CYCLES;
		end
		if (mode_left <= 0) begin
			mode = $urandom_range(0, 3);
			mode_left = $urandom_range(16, 96);
		end
		mode_left--;
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else begin
			case (mode)
				0: out_stall <= 1'b0;
				1: out_stall <= ($urandom_range(0, 9) < 3);
				2: out_stall <= ($urandom_range(0, 9) < 8);
				default: out_stall <= mode_left[2];
			endcase
		end
	end

	// ---------------- Stimulus helpers ----------------
	task automatic write_reg(reg_idx_t idx, logic [31:0] d);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= d;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_PLOT_LEFT:   m_left = d[11:0];
			REG_PLOT_TOP:    m_top = d[11:0];
			REG_PLOT_WIDTH:  m_width = d[11:0];
			REG_PLOT_HEIGHT: m_height = d[11:0];
			REG_X_ORIGIN:    m_xo = d;
			REG_X_GAIN:      m_xg = d;
			REG_Y_ORIGIN:    m_yo = d;
			REG_Y_GAIN:      m_yg = d;
			default: ;
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic set_all(logic [11:0] l, logic [11:0] t, logic [11:0] w, logic [11:0] h,
			logic [31:0] xo, logic [31:0] xg, logic [31:0] yo, logic [31:0] yg);
		write_reg(REG_PLOT_LEFT, 32'(l));
		write_reg(REG_PLOT_TOP, 32'(t));
		write_reg(REG_PLOT_WIDTH, 32'(w));
		write_reg(REG_PLOT_HEIGHT, 32'(h));
		write_reg(REG_X_ORIGIN, xo);
		write_reg(REG_X_GAIN, xg);
		write_reg(REG_Y_ORIGIN, yo);
		write_reg(REG_Y_GAIN, yg);
	endtask

	// Offers one request and waits for it to be taken.
	task automatic send_point(logic [31:0] x, logic [31:0] y, bit s, int typed, path_cmd_t e);
		@(negedge clk);
		in_valid <= 1'b1;
		value_x <= x;
		value_y <= y;
		signal_start <= s;
		row_typed <= typed;
		row_exp <= e;
		do @(posedge clk); while (in_stall);
	endtask

	task automatic pause_sender(int gap);
		@(negedge clk);
		in_valid <= 1'b0;
		repeat (gap) @(negedge clk);
	endtask

	// Waits out every expected command, then the latency of a quiet point.
	task automatic drain();
		pause_sender(0);
		while (cmd_q.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	function automatic logic [31:0] near_value(logic [31:0] origin);
		if ($urandom_range(0, 7) == 0) return $urandom;
		return origin + 32'($signed($urandom_range(0, 163840)) - 49152);
	endfunction

	// Random points in bursts; mostly near the rectangle, some anywhere.
	task automatic random_points(int count);
		int burst;
		path_cmd_t e;
		e = mk(CMD_MOVE, 0, 0);
		burst = 0;
		for (int k = 0; k < count; k++) begin
			if (burst == 0) begin
				burst = $urandom_range(1, 30);
				pause_sender($urandom_range(0, 20));
			end
			burst--;
			send_point(near_value(m_xo), near_value(m_yo), ($urandom_range(0, 19) == 0), -1, e);
		end
	endtask

	point_row_t rows[18];

	task automatic directed_rows();
		path_cmd_t z;
		z = mk(CMD_MOVE, 0, 0);
		rows[0]  = '{32'd0, 32'd0, 1'b1, 1, mk(CMD_MOVE, 0, 7680)};
		rows[1]  = '{32'd32768, 32'd32768, 1'b0, 1, mk(CMD_LINE, 5120, 3840)};
		rows[2]  = '{32'd65536, 32'd65536, 1'b0, 1, mk(CMD_LINE, 10240, 0)};
		rows[3]  = '{32'd131072, 32'd32768, 1'b0, -1, z};
		rows[4]  = '{32'd196608, 32'd32768, 1'b0, 0, z};
		rows[5]  = '{32'd32768, 32'd32768, 1'b0, -1, z};
		rows[6]  = '{32'h7fffffff, 32'h7fffffff, 1'b0, -1, z};
		rows[7]  = '{32'h80000000, 32'h80000000, 1'b0, -1, z};
		rows[8]  = '{32'd16384, 32'd16384, 1'b1, 1, mk(CMD_MOVE, 2560, 5760)};
		rows[9]  = '{-32'sd65536, 32'd16384, 1'b0, -1, z};
		rows[10] = '{-32'sd65536, -32'sd65536, 1'b0, 0, z};
		rows[11] = '{-32'sd32768, 32'd49152, 1'b0, -1, z};
		rows[12] = '{32'd32768, -32'sd65536, 1'b0, -1, z};
		rows[13] = '{32'd32768, -32'sd65536, 1'b1, 0, z};
		rows[14] = '{32'd32768, 32'd32768, 1'b0, 1, mk(CMD_MOVE, 5120, 3840)};
		rows[15] = '{32'd98304, 32'd32768, 1'b0, -1, z};
		rows[16] = '{32'd98304, 32'd131072, 1'b0, 0, z};
		rows[17] = '{32'd32768, 32'd131072, 1'b0, 0, z};
		foreach (rows[i]) begin
			if (rows[i].n_typed > 0) rows[i].e0.lst = 1'b1;
			send_point(rows[i].x, rows[i].y, rows[i].s, rows[i].n_typed, rows[i].e0);
		end
	endtask

	// ---------------- Test sequence ----------------
	initial begin
		m_left = 0; m_top = 0; m_width = 640; m_height = 480;
		m_xo = 0; m_xg = 65536; m_yo = 0; m_yg = 65536;
		m_prev_x = 0; m_prev_y = 0; m_prev_ok = 0; m_started = 0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		directed_rows();
		drain();

		// Largest rectangle, extreme origins and gains.
		set_all(12'hfff, 12'hfff, 12'hfff, 12'hfff,
			32'h80000000, 32'hffffffff, 32'h7fffffff, 32'h0);
		random_points(80);
		drain();

		// Rectangle collapsed to a single point.
		set_all(12'd100, 12'd50, 12'd0, 12'd0, 32'd0, 32'd65536, 32'd0, 32'd65536);
		random_points(60);
		drain();

		// Rectangle collapsed to a line.
		set_all(12'd10, 12'd20, 12'd300, 12'd0, 32'd0, 32'd65536, 32'd0, 32'd65536);
		random_points(60);
		drain();

		for (int ph = 0; ph < 7; ph++) begin
			set_all(12'($urandom_range(0, 300)), 12'($urandom_range(0, 300)),
				12'($urandom_range(1, 900)), 12'($urandom_range(1, 700)),
				32'($signed($urandom_range(0, 2097152)) - 1048576), $urandom_range(32768, 131072),
				32'($signed($urandom_range(0, 2097152)) - 1048576), $urandom_range(32768, 131072));
			if (ph == 2) hold_req = 1'b1;
			random_points(155);
			drain();
		end

		if (errors == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule

// File: sim.f
rtl/pmc_pkg.sv
rtl/pmc_queue.sv
rtl/pmc_front.sv
rtl/pmc_div.sv
rtl/pmc_back.sv
rtl/polyline_map_and_clip_core.sv
tb/sv/tb_polyline_map_and_clip_core.sv
